[rtl/chlcd_pkg.sv]
// shared types and constants for the character lcd queue and nibble writer
`default_nettype none

package chlcd_pkg;

    // request kinds on the cmd field
    localparam logic [1:0] CMD_POSITION = 2'd0;
    localparam logic [1:0] CMD_CHAR     = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_CLEAR_CODE       = 2'd0;
    localparam logic [1:0] REG_CURSOR_LEFT_CODE = 2'd1;
    localparam logic [1:0] REG_LINE_ONE_BASE    = 2'd2;
    localparam logic [1:0] REG_LINE_TWO_BASE    = 2'd3;

    // configuration reset values
    localparam logic [7:0] CLEAR_CODE_RST       = 8'h01;
    localparam logic [7:0] CURSOR_LEFT_CODE_RST = 8'h10;
    localparam logic [6:0] LINE_ONE_BASE_RST    = 7'h00;
    localparam logic [6:0] LINE_TWO_BASE_RST    = 7'h40;

    // control bytes taken from the queue
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_FORM_FEED = 8'h0C;
    localparam logic [7:0] CHR_RETURN    = 8'h0D;

    // set-address commands
    localparam logic [7:0] SET_ADDR_LINE_ONE = 8'h80;
    localparam logic [7:0] SET_ADDR_LINE_TWO = 8'hC0;
    localparam logic [7:0] COLUMN_OFFSET     = 8'h7F;

    localparam logic [1:0] ROW_LINE_TWO = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_LOW    = 3'b100
    } state_t;

endpackage

`default_nettype wire

[rtl/char_lcd_queue_nibble_writer.sv]
// character lcd front end: byte queue in a synchronous ram, decoder and nibble writer
//
// channel    direction  handshake               payload
// request    in         start high, busy low    cmd, column, row, char_byte
// result     out        strobe, one cycle       register_select, nibble, last, overflow
// config     in         cfg_wr_en               cfg_index, cfg_data
//
// a position or character request does not raise busy; a full queue answers with an
// overflow result in the next cycle while busy stays low.
// a service tick reads the queue ram at its accepting edge, decodes in the next cycle,
// has the high nibble on the bus in the cycle after and the low nibble in the one after
// that; busy is high during decode and the high nibble, so the next request can be
// taken as the low nibble goes out; a tick on an empty queue gives no result.
// rst_n clears pointers, line and strobe and loads the configuration defaults;
// the queue ram is not cleared.
// the receiver cannot stall: each result is on the ports for exactly one cycle.
`default_nettype none

module char_lcd_queue_nibble_writer
    import chlcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] cmd,
    input  wire logic [5:0] column,
    input  wire logic [1:0] row,
    input  wire logic [7:0] char_byte,
    // result
    output logic            strobe,
    output logic            register_select,
    output logic [3:0]      nibble,
    output logic            last,
    output logic            overflow,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              line_reg, line_next;
    logic [7:0]        clear_code_reg;
    logic [7:0]        cursor_left_code_reg;
    logic [6:0]        line_one_base_reg;
    logic [6:0]        line_two_base_reg;

    logic              strobe_reg, strobe_next;
    logic              rs_reg, rs_next;
    logic [3:0]        nibble_reg, nibble_next;
    logic              last_reg, last_next;
    logic              overflow_reg, overflow_next;
    logic [3:0]        low_nib_reg, low_nib_next;

    logic [7:0]        queue_mem [QUEUE_DEPTH];
    logic [7:0]        rd_data_reg;

    logic              accept;
    logic              is_push;
    logic              queue_full;
    logic              queue_empty;
    logic              mem_we;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [7:0]        push_byte;
    logic [7:0]        pos_addr;
    logic [6:0]        row_base;
    logic [7:0]        code;
    logic              code_rs;
    logic              code_line;

    // request handshake
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // ring pointers
    assign wr_ptr_inc  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign queue_full  = (wr_ptr_inc == rd_ptr_reg);
    assign queue_empty = (wr_ptr_reg == rd_ptr_reg);

    // set-address byte from column and row
    assign row_base  = (row == ROW_LINE_TWO) ? line_two_base_reg : line_one_base_reg;
    assign pos_addr  = {1'b0, row_base} | ({2'b00, column} + COLUMN_OFFSET);
    assign is_push   = (cmd == CMD_POSITION) || (cmd == CMD_CHAR);
    assign push_byte = (cmd == CMD_POSITION) ? pos_addr : char_byte;
    assign mem_we    = accept && is_push && !queue_full;

    // byte interpretation
    always_comb
    begin
        code      = rd_data_reg;
        code_rs   = 1'b0;
        code_line = line_reg;
        if (rd_data_reg inside {[8'h80:8'h9F]})
        begin
            code_line = 1'b0;
        end
        else if (rd_data_reg inside {[8'hC0:8'hDF]})
        begin
            code_line = 1'b1;
        end
        else
        begin
            case (rd_data_reg)
                CHR_FORM_FEED:
                begin
                    code      = clear_code_reg;
                    code_line = 1'b0;
                end
                CHR_NEWLINE:
                begin
                    code_line = !line_reg;
                    code      = line_reg ? SET_ADDR_LINE_ONE : SET_ADDR_LINE_TWO;
                end
                CHR_BACKSPACE:
                begin
                    code = cursor_left_code_reg;
                end
                CHR_RETURN:
                begin
                    code = {1'b1, (line_reg ? line_two_base_reg : line_one_base_reg)};
                end
                default:
                begin
                    code_rs = 1'b1;
                end
            endcase
        end
    end

    // sequencer and result registers
    always_comb
    begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        line_next     = line_reg;
        strobe_next   = 1'b0;
        rs_next       = rs_reg;
        nibble_next   = nibble_reg;
        last_next     = last_reg;
        overflow_next = overflow_reg;
        low_nib_next  = low_nib_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_POSITION, CMD_CHAR:
                        begin
                            if (cmd == CMD_POSITION)
                            begin
                                line_next = (row == ROW_LINE_TWO);
                            end
                            if (queue_full)
                            begin
                                strobe_next   = 1'b1;
                                rs_next       = 1'b0;
                                nibble_next   = 4'h0;
                                last_next     = 1'b0;
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                wr_ptr_next = wr_ptr_inc;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (!queue_empty)
                            begin
                                rd_ptr_next = rd_ptr_inc;
                                state_next  = ST_DECODE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DECODE:
            begin
                line_next     = code_line;
                strobe_next   = 1'b1;
                rs_next       = code_rs;
                nibble_next   = code[7:4];
                last_next     = 1'b0;
                overflow_next = 1'b0;
                low_nib_next  = code[3:0];
                state_next    = ST_LOW;
            end
            ST_LOW:
            begin
                strobe_next = 1'b1;
                nibble_next = low_nib_reg;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            line_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            line_reg   <= line_next;
            strobe_reg <= strobe_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_code_reg       <= CLEAR_CODE_RST;
            cursor_left_code_reg <= CURSOR_LEFT_CODE_RST;
            line_one_base_reg    <= LINE_ONE_BASE_RST;
            line_two_base_reg    <= LINE_TWO_BASE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CLEAR_CODE:       clear_code_reg       <= cfg_data;
                REG_CURSOR_LEFT_CODE: cursor_left_code_reg <= cfg_data;
                REG_LINE_ONE_BASE:    line_one_base_reg    <= cfg_data[6:0];
                REG_LINE_TWO_BASE:    line_two_base_reg    <= cfg_data[6:0];
                default:              clear_code_reg       <= clear_code_reg;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rs_reg       <= rs_next;
        nibble_reg   <= nibble_next;
        last_reg     <= last_next;
        overflow_reg <= overflow_next;
        low_nib_reg  <= low_nib_next;
    end

    // queue ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[wr_ptr_reg] <= push_byte;
        end
        rd_data_reg <= queue_mem[rd_ptr_reg];
    end

    assign strobe          = strobe_reg;
    assign register_select = rs_reg;
    assign nibble          = nibble_reg;
    assign last            = last_reg;
    assign overflow        = overflow_reg;

`ifndef SYNTHESIS
    // low nibble always follows a high nibble of the same byte
    a_low_after_high: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> $past(strobe && !last && !overflow))
        else $error("low nibble without preceding high nibble");

    // while the low nibble is pending the high nibble is on the bus
    a_low_state_high: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOW) |-> (strobe && !last && !overflow))
        else $error("low nibble state without high nibble result");

    // an overflow result comes from a dropped push taken while idle
    a_overflow_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && overflow) |-> (!busy && !last && $past(accept && is_push && queue_full)))
        else $error("overflow result without a dropped request");

    // a tick only decodes when the queue held a byte
    a_tick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECODE) |-> $past(accept && (cmd == CMD_TICK) && !queue_empty))
        else $error("decode entered without a queued byte");
`endif

endmodule

`default_nettype wire

[verif/tb_char_lcd_queue_nibble_writer.sv]
// self-checking testbench for the character lcd queue and nibble writer
module tb_char_lcd_queue_nibble_writer
    import chlcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] column;
        logic [1:0] row;
        logic [7:0] char_byte;
    } lcd_request_t;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
        logic       overflow;
    } bus_write_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] cmd = CMD_POSITION;
    logic [5:0] column = '0;
    logic [1:0] row = '0;
    logic [7:0] char_byte = '0;
    logic       strobe;
    logic       register_select;
    logic [3:0] nibble;
    logic       last;
    logic       overflow;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = REG_CLEAR_CODE;
    logic [7:0] cfg_data = '0;

    // requests waiting for the driver and bus writes waiting for the monitor
    lcd_request_t request_queue[$];
    bus_write_t   expected_writes[$];

    // shadow of the display queue, line and settings
    logic [7:0]       ring_bytes [QUEUE_DEPTH];
    logic [PTR_W-1:0] ring_wr = '0;
    logic [PTR_W-1:0] ring_rd = '0;
    logic             on_line_two = 1'b0;
    logic [7:0]       clear_byte = CLEAR_CODE_RST;
    logic [7:0]       cursor_left_byte = CURSOR_LEFT_CODE_RST;
    logic [6:0]       line_one_addr = LINE_ONE_BASE_RST;
    logic [6:0]       line_two_addr = LINE_TWO_BASE_RST;

    logic req_taken = 1'b0;
    bit   idle_on = 1'b1;
    int   gap_left = 0;
    int   error_count = 0;

    char_lcd_queue_nibble_writer #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .column(column),
        .row(row),
        .char_byte(char_byte),
        .strobe(strobe),
        .register_select(register_select),
        .nibble(nibble),
        .last(last),
        .overflow(overflow),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic lcd_request_t make_request(logic [1:0] kind, logic [5:0] col,
                                                  logic [1:0] line_sel, logic [7:0] b);
        lcd_request_t r;
        r.cmd = kind;
        r.column = col;
        r.row = line_sel;
        r.char_byte = b;
        return r;
    endfunction

    // byte mix leaning on control bytes, address commands and range borders
    function automatic logic [7:0] pick_char();
        logic [7:0] b;
        case ($urandom_range(9))
            0: case ($urandom_range(3))
                   0: b = CHR_BACKSPACE;
                   1: b = CHR_NEWLINE;
                   2: b = CHR_FORM_FEED;
                   default: b = CHR_RETURN;
               endcase
            1: b = 8'($urandom_range(8'h80, 8'h9F));
            2: b = 8'($urandom_range(8'hC0, 8'hDF));
            3: case ($urandom_range(5))
                   0: b = 8'h7F;
                   1: b = 8'hA0;
                   2: b = 8'hBF;
                   3: b = 8'hE0;
                   4: b = 8'h00;
                   default: b = 8'hFF;
               endcase
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic push_write(logic rs, logic [3:0] nib, logic fin, logic ovf);
        bus_write_t w;
        w.register_select = rs;
        w.nibble = nib;
        w.last = fin;
        w.overflow = ovf;
        expected_writes.push_back(w);
    endtask

    // queue a byte, or flag a drop when the ring is full
    task automatic enqueue_byte(logic [7:0] b);
        if (PTR_W'(ring_wr + 1'b1) == ring_rd)
        begin
            push_write(1'b0, 4'h0, 1'b0, 1'b1);
        end
        else
        begin
            ring_bytes[ring_wr] = b;
            ring_wr = PTR_W'(ring_wr + 1'b1);
        end
    endtask

    // expected bus writes for one accepted request
    task automatic decode_request(lcd_request_t r);
        logic [7:0] addr;
        logic [7:0] b;
        logic [7:0] code;
        logic       rs;
        case (r.cmd)
            CMD_POSITION:
            begin
                addr = 8'h80 + r.column - 8'd1;
                on_line_two = (r.row == ROW_LINE_TWO);
                addr = addr | {1'b0, on_line_two ? line_two_addr : line_one_addr};
                enqueue_byte(addr);
            end
            CMD_CHAR:
                enqueue_byte(r.char_byte);
            CMD_TICK:
            begin
                if (ring_rd != ring_wr)
                begin
                    b = ring_bytes[ring_rd];
                    ring_rd = PTR_W'(ring_rd + 1'b1);
                    rs = 1'b0;
                    if (b >= 8'h80 && b <= 8'h9F)
                    begin
                        on_line_two = 1'b0;
                        code = b;
                    end
                    else if (b >= 8'hC0 && b <= 8'hDF)
                    begin
                        on_line_two = 1'b1;
                        code = b;
                    end
                    else if (b == CHR_FORM_FEED)
                    begin
                        on_line_two = 1'b0;
                        code = clear_byte;
                    end
                    else if (b == CHR_NEWLINE)
                    begin
                        on_line_two = ~on_line_two;
                        code = on_line_two ? SET_ADDR_LINE_TWO : SET_ADDR_LINE_ONE;
                    end
                    else if (b == CHR_BACKSPACE)
                    begin
                        code = cursor_left_byte;
                    end
                    else if (b == CHR_RETURN)
                    begin
                        code = {1'b0, on_line_two ? line_two_addr : line_one_addr} | 8'h80;
                    end
                    else
                    begin
                        code = b;
                        rs = 1'b1;
                    end
                    push_write(rs, code[7:4], 1'b0, 1'b0);
                    push_write(rs, code[3:0], 1'b1, 1'b0);
                end
            end
            default: ;
        endcase
    endtask

    // request driver, changes inputs on the falling edge
    always @(negedge clk)
    begin
        lcd_request_t nxt;
        logic drive;
        drive = 1'b0;
        nxt = '0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (request_queue.size() > 0)
            begin
                nxt = request_queue.pop_front();
                drive = 1'b1;
                gap_left = pick_gap();
            end
            start <= drive;
            if (drive)
            begin
                cmd <= nxt.cmd;
                column <= nxt.column;
                row <= nxt.row;
                char_byte <= nxt.char_byte;
            end
        end
    end

    // monitor: check bus writes, track settings, predict on each accepted request
    always @(posedge clk)
    begin
        bus_write_t exp_w;
        req_taken = rst_n && start && !busy;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected bus write: rs %0d nibble %0h last %0d overflow %0d",
                           register_select, nibble, last, overflow);
                    error_count++;
                end
                else
                begin
                    exp_w = expected_writes.pop_front();
                    if (register_select !== exp_w.register_select)
                    begin
                        $error("register_select: expected %0d, got %0d",
                               exp_w.register_select, register_select);
                        error_count++;
                    end
                    if (nibble !== exp_w.nibble)
                    begin
                        $error("nibble: expected %0h, got %0h", exp_w.nibble, nibble);
                        error_count++;
                    end
                    if (last !== exp_w.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_w.last, last);
                        error_count++;
                    end
                    if (overflow !== exp_w.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", exp_w.overflow, overflow);
                        error_count++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CLEAR_CODE:       clear_byte = cfg_data;
                    REG_CURSOR_LEFT_CODE: cursor_left_byte = cfg_data;
                    REG_LINE_ONE_BASE:    line_one_addr = cfg_data[6:0];
                    REG_LINE_TWO_BASE:    line_two_addr = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (req_taken)
                decode_request(make_request(cmd, column, row, char_byte));
        end
    end

    // wait until every request is sent and every bus write has come
    task automatic wait_drained();
        while (request_queue.size() > 0 || start || expected_writes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(logic [7:0] clr, logic [7:0] left,
                                  logic [7:0] one, logic [7:0] two);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CLEAR_CODE;
        cfg_data <= clr;
        @(negedge clk);
        cfg_index <= REG_CURSOR_LEFT_CODE;
        cfg_data <= left;
        @(negedge clk);
        cfg_index <= REG_LINE_ONE_BASE;
        cfg_data <= one;
        @(negedge clk);
        cfg_index <= REG_LINE_TWO_BASE;
        cfg_data <= two;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int enq_pct;
        int counted;
        int r;
        lcd_request_t req;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: positions at columns 0, 1 and 32, every control byte, both address ranges
        request_queue.push_back(make_request(CMD_POSITION, 6'd1, 2'd0, 8'h00));
        request_queue.push_back(make_request(CMD_POSITION, 6'd32, ROW_LINE_TWO, 8'hFF));
        request_queue.push_back(make_request(CMD_POSITION, 6'd0, 2'd3, 8'h00));
        request_queue.push_back(make_request(CMD_CHAR, 6'd63, 2'd1, 8'h00));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, 8'hFF));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, CHR_NEWLINE));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, CHR_RETURN));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, CHR_NEWLINE));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, CHR_RETURN));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, CHR_FORM_FEED));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, CHR_BACKSPACE));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, 8'h9F));
        request_queue.push_back(make_request(CMD_CHAR, 6'd0, 2'd0, 8'hC0));
        request_queue.push_back(make_request(CMD_UNUSED, 6'd63, 2'd3, 8'hFF));
        repeat (14) request_queue.push_back(make_request(CMD_TICK, 6'd0, 2'd0, 8'h00));
        wait_drained();

        // random phases: filling, draining and balanced, under several settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255)));
                1: apply_settings(8'h00, 8'h00, 8'h00, 8'h00);
                2: apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: ;
            endcase
            case (phase % 3)
                0: enq_pct = 85;
                1: enq_pct = 25;
                default: enq_pct = 55;
            endcase
            idle_on = (phase % 5 != 2);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                req = make_request(CMD_TICK, 6'($urandom_range(63)), 2'($urandom_range(3)),
                                   pick_char());
                if (r < enq_pct)
                    req.cmd = ($urandom_range(3) == 0) ? CMD_POSITION : CMD_CHAR;
                else if (r >= 98)
                    req.cmd = CMD_UNUSED;
                if (req.cmd != CMD_UNUSED)
                    counted++;
                request_queue.push_back(req);
            end
            wait_drained();
        end

        if (expected_writes.size() > 0)
        begin
            $error("%0d bus writes never came", expected_writes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
